// ----- hw/rtl/segment_intersection_test_unit_assert.svh -----
// assertion macros used by segment_intersection_test_unit.sv
`ifndef SEGMENT_INTERSECTION_TEST_UNIT_ASSERT_SVH
`define SEGMENT_INTERSECTION_TEST_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SIT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SIT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/sit_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int NUM_CROSS = 4;
	localparam int OUT_BYTES_BITS = 8;

	// bounding-box results for one segment pair
	typedef struct packed {
		logic hit;
		logic vs_in_first;
		logic ve_in_first;
		logic ue_in_second;
		logic us_in_second;
	} sit_box_t;

	// load enables of the stages inside the cross product units
	typedef struct packed {
		logic s2;
		logic s3;
	} sit_stage_en_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sit_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sit_front #(
	parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          en_s1,
	input  wire logic [8*COORD_BITS-1:0]       coords,
	output logic signed [COORD_BITS:0]         op_a_s1 [sit_pkg::NUM_CROSS],
	output logic signed [COORD_BITS:0]         op_b_s1 [sit_pkg::NUM_CROSS],
	output logic signed [COORD_BITS:0]         op_c_s1 [sit_pkg::NUM_CROSS],
	output logic signed [COORD_BITS:0]         op_d_s1 [sit_pkg::NUM_CROSS],
	output sit_pkg::sit_box_t                  box_s1
);
	import sit_pkg::*;

	localparam int C = COORD_BITS;

	logic signed [C-1:0] usx, usy, uex, uey, vsx, vsy, vex, vey;
	logic signed [C-1:0] f_minx, f_maxx, f_miny, f_maxy;
	logic signed [C-1:0] s_minx, s_maxx, s_miny, s_maxy;
	logic signed [C:0]   a_n [NUM_CROSS];
	logic signed [C:0]   b_n [NUM_CROSS];
	logic signed [C:0]   c_n [NUM_CROSS];
	logic signed [C:0]   d_n [NUM_CROSS];
	sit_box_t            box_n;

	function automatic logic signed [C:0] sub_ext(input logic signed [C-1:0] p,
			input logic signed [C-1:0] q);
		sub_ext = {p[C-1], p} - {q[C-1], q};
	endfunction

	always_comb begin
		usx = $signed(coords[0*C +: C]);
		usy = $signed(coords[1*C +: C]);
		uex = $signed(coords[2*C +: C]);
		uey = $signed(coords[3*C +: C]);
		vsx = $signed(coords[4*C +: C]);
		vsy = $signed(coords[5*C +: C]);
		vex = $signed(coords[6*C +: C]);
		vey = $signed(coords[7*C +: C]);

		f_minx = (usx < uex) ? usx : uex;
		f_maxx = (usx > uex) ? usx : uex;
		f_miny = (usy < uey) ? usy : uey;
		f_maxy = (usy > uey) ? usy : uey;
		s_minx = (vsx < vex) ? vsx : vex;
		s_maxx = (vsx > vex) ? vsx : vex;
		s_miny = (vsy < vey) ? vsy : vey;
		s_maxy = (vsy > vey) ? vsy : vey;

		// unit 0: (vs - us) x (ue - us)
		a_n[0] = sub_ext(vsx, usx); d_n[0] = sub_ext(uey, usy);
		b_n[0] = sub_ext(uex, usx); c_n[0] = sub_ext(vsy, usy);
		// unit 1: (ue - us) x (ve - us)
		a_n[1] = sub_ext(uex, usx); d_n[1] = sub_ext(vey, usy);
		b_n[1] = sub_ext(vex, usx); c_n[1] = sub_ext(uey, usy);
		// unit 2: (us - vs) x (ve - vs)
		a_n[2] = sub_ext(usx, vsx); d_n[2] = sub_ext(vey, vsy);
		b_n[2] = sub_ext(vex, vsx); c_n[2] = sub_ext(usy, vsy);
		// unit 3: (ve - vs) x (ue - vs)
		a_n[3] = sub_ext(vex, vsx); d_n[3] = sub_ext(uey, vsy);
		b_n[3] = sub_ext(uex, vsx); c_n[3] = sub_ext(vey, vsy);

		box_n.hit = (f_maxx >= s_minx) && (s_maxx >= f_minx) &&
			(f_maxy >= s_miny) && (s_maxy >= f_miny);
		box_n.vs_in_first = (vsx >= f_minx) && (vsx <= f_maxx) &&
			(vsy >= f_miny) && (vsy <= f_maxy);
		box_n.ve_in_first = (vex >= f_minx) && (vex <= f_maxx) &&
			(vey >= f_miny) && (vey <= f_maxy);
		box_n.ue_in_second = (uex >= s_minx) && (uex <= s_maxx) &&
			(uey >= s_miny) && (uey <= s_maxy);
		box_n.us_in_second = (usx >= s_minx) && (usx <= s_maxx) &&
			(usy >= s_miny) && (usy <= s_maxy);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			op_a_s1 <= a_n;
			op_b_s1 <= b_n;
			op_c_s1 <= c_n;
			op_d_s1 <= d_n;
			box_s1  <= box_n;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/sit_cross.sv -----
`timescale 1ns / 1ps
`default_nettype none

// sign of a*d - b*c, exact: products in stage 2, difference in stage 3
module sit_cross #(
	parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire sit_pkg::sit_stage_en_t     en,
	input  wire logic signed [COORD_BITS:0] op_a,
	input  wire logic signed [COORD_BITS:0] op_b,
	input  wire logic signed [COORD_BITS:0] op_c,
	input  wire logic signed [COORD_BITS:0] op_d,
	output logic                            neg_s3,
	output logic                            zero_s3
);
	import sit_pkg::*;

	localparam int PW = 2 * COORD_BITS + 2;

	logic signed [PW-1:0] prod_ad_s2, prod_bc_s2;
	logic signed [PW:0]   diff;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_ad_s2 <= op_a * op_d;
			prod_bc_s2 <= op_b * op_c;
		end
	end

	assign diff = {prod_ad_s2[PW-1], prod_ad_s2} - {prod_bc_s2[PW-1], prod_bc_s2};

	always_ff @(posedge clk) begin
		if (en.s3) begin
			neg_s3  <= diff[PW];
			zero_s3 <= (diff == '0);
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/segment_intersection_test_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Tests one pair of integer segments per transfer and returns touches and
// crosses_properly. Each pair passes through registered stages in order:
// operand differences and bounding boxes, the exact cross products, their
// signs, then the result. A new pair is taken every cycle; throughput is one
// pair per clock, limited only by the output side. The cross product stage
// with its (COORD_BITS+1)-bit multipliers sets the clock rate.
module segment_intersection_test_unit #(
	parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	// first_start_x, first_start_y, first_end_x, first_end_y,
	// second_start_x, second_start_y, second_end_x, second_end_y
	input  wire logic [8*COORD_BITS-1:0]      s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// touches, crosses_properly, zero fill
	output logic [sit_pkg::OUT_BYTES_BITS-1:0] m_axis_tdata
);
	import sit_pkg::*;

	`include "segment_intersection_test_unit_assert.svh"

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic en_s1, en_s2, en_s3, en_s4;
	sit_stage_en_t cross_en;

	logic signed [COORD_BITS:0] op_a_s1 [NUM_CROSS];
	logic signed [COORD_BITS:0] op_b_s1 [NUM_CROSS];
	logic signed [COORD_BITS:0] op_c_s1 [NUM_CROSS];
	logic signed [COORD_BITS:0] op_d_s1 [NUM_CROSS];
	sit_box_t box_s1, box_s2, box_s3;
	logic [NUM_CROSS-1:0] neg_s3, zero_s3;
	logic hit, proper;
	logic touches_s4, crosses_properly_s4;

	// a stage loads when it is empty or its contents move on
	assign en_s4 = !vld_s4 || m_axis_tready;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign s_axis_tready = en_s1;
	assign cross_en.s2 = en_s2;
	assign cross_en.s3 = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= s_axis_tvalid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
		end
	end

	sit_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk     (clk),
		.en_s1   (en_s1),
		.coords  (s_axis_tdata),
		.op_a_s1 (op_a_s1),
		.op_b_s1 (op_b_s1),
		.op_c_s1 (op_c_s1),
		.op_d_s1 (op_d_s1),
		.box_s1  (box_s1)
	);

	for (genvar k = 0; k < NUM_CROSS; k++) begin : g_cross
		sit_cross #(.COORD_BITS(COORD_BITS)) u_cross (
			.clk     (clk),
			.en      (cross_en),
			.op_a    (op_a_s1[k]),
			.op_b    (op_b_s1[k]),
			.op_c    (op_c_s1[k]),
			.op_d    (op_d_s1[k]),
			.neg_s3  (neg_s3[k]),
			.zero_s3 (zero_s3[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en_s2) box_s2 <= box_s1;
		if (en_s3) box_s3 <= box_s2;
	end

	// straddle: product of signs >= 0 means one is zero or both agree;
	// an endpoint lies on the other segment when collinear and inside its box
	always_comb begin
		hit = box_s3.hit &&
			(zero_s3[0] || zero_s3[1] || (neg_s3[0] == neg_s3[1])) &&
			(zero_s3[2] || zero_s3[3] || (neg_s3[2] == neg_s3[3]));
		proper = hit &&
			!(zero_s3[0] && box_s3.vs_in_first) &&
			!(zero_s3[1] && box_s3.ve_in_first) &&
			!(zero_s3[3] && box_s3.ue_in_second) &&
			!(zero_s3[2] && box_s3.us_in_second);
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			touches_s4          <= hit;
			crosses_properly_s4 <= proper;
		end
	end

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = {{(OUT_BYTES_BITS-2){1'b0}}, crosses_properly_s4, touches_s4};

	`SIT_ASSERT_NOW(a_proper_touch, m_axis_tvalid && crosses_properly_s4, touches_s4, "proper, no touch")
	`SIT_ASSERT_NEXT(a_s3_to_s4, vld_s3 && en_s4, vld_s4, "item lost before output")
	`SIT_ASSERT_NOW(a_stall_full, !s_axis_tready, vld_s1 && vld_s2 && vld_s3 && vld_s4, "stall w/ bubble")

endmodule

`default_nettype wire

// ----- tb/sv/segment_intersection_test_unit_checker.sv -----
`timescale 1ns / 1ps

module segment_intersection_test_unit_checker #(
	parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	input  wire logic                          s_axis_tready,
	input  wire logic [8*COORD_BITS-1:0]       s_axis_tdata,
	input  wire logic                          m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	input  wire logic [sit_pkg::OUT_BYTES_BITS-1:0] m_axis_tdata,
	output int                                 failures,
	output int                                 pending,
	output int                                 pairs_checked,
	output int                                 touch_count,
	output int                                 proper_count
);
	import sit_pkg::*;

	typedef struct {
		longint x;
		longint y;
	} point_t;

	typedef struct packed {
		logic crosses_properly;
		logic touches;
	} contact_t;

	contact_t contact_q[$];
	contact_t want;
	contact_t got;

	// sign of (a - o) x (b - o); coordinates are narrow, so longint is exact
	function automatic int turn(input point_t a, input point_t b, input point_t o);
		longint v;
		v = (a.x - o.x) * (b.y - o.y) - (b.x - o.x) * (a.y - o.y);
		if (v > 0)
			return 1;
		else if (v < 0)
			return -1;
		return 0;
	endfunction

	function automatic bit lies_on(input point_t s, input point_t e, input point_t p);
		return turn(e, p, s) == 0 &&
			p.x >= ((s.x < e.x) ? s.x : e.x) && p.x <= ((s.x > e.x) ? s.x : e.x) &&
			p.y >= ((s.y < e.y) ? s.y : e.y) && p.y <= ((s.y > e.y) ? s.y : e.y);
	endfunction

	function automatic contact_t predict_contact(input logic [8*COORD_BITS-1:0] d);
		point_t us, ue, vs, ve;
		contact_t r;
		bit hit;
		us.x = longint'($signed(d[0*COORD_BITS +: COORD_BITS]));
		us.y = longint'($signed(d[1*COORD_BITS +: COORD_BITS]));
		ue.x = longint'($signed(d[2*COORD_BITS +: COORD_BITS]));
		ue.y = longint'($signed(d[3*COORD_BITS +: COORD_BITS]));
		vs.x = longint'($signed(d[4*COORD_BITS +: COORD_BITS]));
		vs.y = longint'($signed(d[5*COORD_BITS +: COORD_BITS]));
		ve.x = longint'($signed(d[6*COORD_BITS +: COORD_BITS]));
		ve.y = longint'($signed(d[7*COORD_BITS +: COORD_BITS]));
		// bounding boxes must overlap, then each segment must straddle the other's line
		hit = ((us.x > ue.x) ? us.x : ue.x) >= ((vs.x < ve.x) ? vs.x : ve.x) &&
			((vs.x > ve.x) ? vs.x : ve.x) >= ((us.x < ue.x) ? us.x : ue.x) &&
			((us.y > ue.y) ? us.y : ue.y) >= ((vs.y < ve.y) ? vs.y : ve.y) &&
			((vs.y > ve.y) ? vs.y : ve.y) >= ((us.y < ue.y) ? us.y : ue.y) &&
			turn(vs, ue, us) * turn(ue, ve, us) >= 0 &&
			turn(us, ve, vs) * turn(ve, ue, vs) >= 0;
		r.touches = hit;
		r.crosses_properly = hit && !lies_on(us, ue, vs) && !lies_on(us, ue, ve) &&
			!lies_on(vs, ve, ue) && !lies_on(vs, ve, us);
		return r;
	endfunction

	initial begin
		failures = 0;
		pending = 0;
		pairs_checked = 0;
		touch_count = 0;
		proper_count = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				contact_q.push_back(predict_contact(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				got.touches = m_axis_tdata[0];
				got.crosses_properly = m_axis_tdata[1];
				if (contact_q.size() == 0) begin
					$error("result transfer with no segment pair outstanding: tdata=%h",
						m_axis_tdata);
					failures++;
				end else begin
					want = contact_q.pop_front();
					pairs_checked++;
					if (want.touches)
						touch_count++;
					if (want.crosses_properly)
						proper_count++;
					if (got.touches !== want.touches) begin
						$error("touches: expected %0b, actual %0b", want.touches, got.touches);
						failures++;
					end
					if (got.crosses_properly !== want.crosses_properly) begin
						$error("crosses_properly: expected %0b, actual %0b",
							want.crosses_properly, got.crosses_properly);
						failures++;
					end
					if (m_axis_tdata[OUT_BYTES_BITS-1:2] !== '0) begin
						$error("zero fill: expected 0, actual %h",
							m_axis_tdata[OUT_BYTES_BITS-1:2]);
						failures++;
					end
				end
			end
			pending = contact_q.size();
		end
	end

endmodule

// ----- tb/sv/segment_intersection_test_unit_test.sv -----
`timescale 1ns / 1ps

module segment_intersection_test_unit_test;
	import sit_pkg::*;

	localparam int COORD_BITS = sit_pkg::COORD_BITS_DEF;
	localparam int PAIR_BITS = 8 * COORD_BITS;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_PAIRS = 376;

	typedef enum int {
		PAIR_UNIFORM,
		PAIR_NEARBY,
		PAIR_SHARED_END,
		PAIR_COLLINEAR,
		PAIR_POINT,
		PAIR_END_ON_SEG
	} pair_kind_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// first_start_x, first_start_y, first_end_x, first_end_y,
	// second_start_x, second_start_y, second_end_x, second_end_y
	logic [PAIR_BITS-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// touches, crosses_properly, zero fill
	logic [OUT_BYTES_BITS-1:0] m_axis_tdata;

	int failures;
	int pending;
	int pairs_checked;
	int touch_count;
	int proper_count;

	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;
	int hold_left;

	segment_intersection_test_unit #(
		.COORD_BITS(COORD_BITS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	segment_intersection_test_unit_checker #(
		.COORD_BITS(COORD_BITS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.failures(failures),
		.pending(pending),
		.pairs_checked(pairs_checked),
		.touch_count(touch_count),
		.proper_count(proper_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [PAIR_BITS-1:0] pack_pair(input int c[8]);
		logic [PAIR_BITS-1:0] d;
		for (int i = 0; i < 8; i++)
			d[i*COORD_BITS +: COORD_BITS] = c[i][COORD_BITS-1:0];
		return d;
	endfunction

	function automatic int spread(input int half);
		return int'($urandom_range(2 * half)) - half;
	endfunction

	function automatic logic [PAIR_BITS-1:0] random_pair(input pair_kind_t kind);
		int c[8];
		int bx, by, dx, dy, k, j, t;
		unique case (kind)
			PAIR_UNIFORM: begin
				for (int i = 0; i < 8; i++)
					c[i] = int'($urandom_range(65535));
			end
			PAIR_NEARBY: begin
				for (int i = 0; i < 8; i++)
					c[i] = spread(6);
			end
			PAIR_SHARED_END: begin
				bx = spread(20000);
				by = spread(20000);
				for (int i = 0; i < 8; i++)
					c[i] = ((i % 2) ? by : bx) + spread(1000);
				j = $urandom_range(1);
				k = $urandom_range(1);
				c[4 + 2*k] = c[2*j];
				c[5 + 2*k] = c[2*j + 1];
			end
			PAIR_COLLINEAR: begin
				bx = spread(30000);
				by = spread(30000);
				dx = spread(40);
				dy = spread(40);
				for (int i = 0; i < 4; i++) begin
					k = spread(20);
					c[2*i] = bx + k * dx;
					c[2*i + 1] = by + k * dy;
				end
			end
			PAIR_POINT: begin
				// other segment spans four steps, the point sits on a step or just past it
				bx = spread(20000);
				by = spread(20000);
				dx = spread(200);
				dy = spread(200);
				k = $urandom_range(5);
				c[0] = bx;
				c[1] = by;
				c[2] = bx + 4 * dx;
				c[3] = by + 4 * dy;
				c[4] = bx + k * dx;
				c[5] = by + k * dy;
				if ($urandom_range(3) == 0) begin
					c[4] += spread(2);
					c[5] += spread(2);
				end
				c[6] = c[4];
				c[7] = c[5];
			end
			default: begin
				bx = spread(20000);
				by = spread(20000);
				dx = spread(500);
				dy = spread(500);
				k = $urandom_range(4);
				c[0] = bx;
				c[1] = by;
				c[2] = bx + 4 * dx;
				c[3] = by + 4 * dy;
				c[4] = bx + k * dx;
				c[5] = by + k * dy;
				c[6] = bx + spread(3000);
				c[7] = by + spread(3000);
			end
		endcase
		if ($urandom_range(1)) begin
			for (int i = 0; i < 4; i++) begin
				t = c[i];
				c[i] = c[i + 4];
				c[i + 4] = t;
			end
		end
		return pack_pair(c);
	endfunction

	function automatic pair_kind_t pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 30)
			return PAIR_UNIFORM;
		else if (r < 50)
			return PAIR_NEARBY;
		else if (r < 60)
			return PAIR_SHARED_END;
		else if (r < 75)
			return PAIR_COLLINEAR;
		else if (r < 85)
			return PAIR_POINT;
		return PAIR_END_ON_SEG;
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_pair(input logic [PAIR_BITS-1:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic send_coords(input int fsx, input int fsy, input int fex, input int fey,
		input int ssx, input int ssy, input int sex, input int sey);
		int c[8];
		c = '{fsx, fsy, fex, fey, ssx, ssy, sex, sey};
		send_pair(pack_pair(c));
	endtask

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++)
			send_pair(random_pair(pick_kind()));
	endtask

	// output side: random stalls, plus one long hold when asked
	initial begin
		m_axis_tready = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, pending);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		hold_req = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes of the coordinate range
		send_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		send_coords(-32768, 32767, 32767, 32767, -32768, -32768, 32767, -32768);
		send_coords(-32768, -32768, 32767, 32767, -32768, -32767, 32766, 32767);
		send_coords(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
		// proper crossing and clear miss
		send_coords(0, 0, 10, 10, 0, 10, 10, 0);
		send_coords(0, 0, 10, 10, 20, 0, 30, 10);
		// shared endpoint and t junction
		send_coords(0, 0, 10, 0, 10, 0, 10, 10);
		send_coords(0, 0, 10, 0, 5, 0, 5, 10);
		// straddle fails although the boxes overlap
		send_coords(0, 0, 10, 10, 6, 4, 10, 0);
		// collinear overlap, contained, end to end, disjoint
		send_coords(0, 0, 10, 10, 5, 5, 15, 15);
		send_coords(-4, 2, 8, -4, 0, 0, 4, -2);
		send_coords(0, 0, 4, 4, 4, 4, 8, 8);
		send_coords(0, 0, 4, 4, 5, 5, 9, 9);
		send_coords(0, 0, 0, 6, 0, 7, 0, 9);
		// parallel, not collinear
		send_coords(0, 0, 10, 0, 0, 1, 10, 1);
		// degenerate segments: on, off, at an end, point on point, point off point
		send_coords(0, 0, 10, 10, 4, 4, 4, 4);
		send_coords(0, 0, 10, 10, 4, 5, 4, 5);
		send_coords(7, -3, 7, -3, 7, -3, 12, 9);
		send_coords(3, 3, 3, 3, 3, 3, 3, 3);
		send_coords(3, 3, 3, 3, 3, 4, 3, 4);
		send_coords(-32768, 32767, -32768, 32767, -32768, 32767, 32767, -32768);

		send_idle_pct = 8;
		recv_idle_pct = 64;
		random_phase(PHASE_PAIRS);

		send_idle_pct = 64;
		recv_idle_pct = 8;
		random_phase(PHASE_PAIRS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(40);
		hold_req = 1'b1;
		random_phase(PHASE_PAIRS - 40);

		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d segment pairs checked: %0d touching, %0d crossing properly",
			pairs_checked, touch_count, proper_count);
		$display("corners, collinear, degenerate and endpoint contacts; %0d-cycle output hold",
			HOLD_CYCLES);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
